// File: rtl/core/cascaded_biquad_iir_filter_macros.svh
// assertion macros shared by the biquad cascade checker
`ifndef CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH

// property checked on the rising edge, ignored while reset is asserted
`define CBQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define CBQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cbq_pkg.sv
// shared constants and types for the cascaded biquad filter
package cbq_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int COEF_FRAC    = 29;
    localparam int SLOTS        = 5;

    localparam int CFG_W      = 5;
    localparam int SECIDX_W   = 4;
    localparam int SLOT_W     = 3;
    localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int COEF_DEPTH = MAX_SECTIONS * SLOTS;
    localparam int CADDR_W    = $clog2(COEF_DEPTH);
    localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W      = PROD_W + 3;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam logic REG_SECTION_COUNT = 1'b0;

    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/cascaded_biquad_iir_filter.sv
// cascaded direct-form-1 biquad filter around one shared multiply-accumulate unit
// N = sections in use (1..16); each sample passes through them one after another
// one sample at a time: input stalls until the result reaches the output register
//   (single shared multiplier: five products per section, pipeline drain, write-back step)
// coefficient writes give no result
// synchronous active-low reset clears delays, coefficient valid bits and section count (to 1)
module cascaded_biquad_iir_filter (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic                                      i_func,
    input  logic signed [cbq_pkg::SAMPLE_BITS-1:0]    i_sample_in,
    input  logic        [cbq_pkg::SECIDX_W-1:0]       i_coef_section,
    input  logic        [cbq_pkg::SLOT_W-1:0]         i_coef_slot,
    input  logic signed [cbq_pkg::COEF_BITS-1:0]      i_coef_value,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [cbq_pkg::SAMPLE_BITS-1:0]    o_sample_out,
    output logic                                      o_saturated,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);
    import cbq_pkg::*;

    // sequencer
    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0] r_section_count;
    logic [SEC_W-1:0] last_idx;
    logic             cfg_wr;

    // coefficient store, valid bit per entry stands in for the zero reset
    logic signed [COEF_BITS-1:0] r_coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]       r_coef_vld;
    logic signed [COEF_BITS-1:0] r_coef_q;
    logic                        r_cvld_q;
    logic [CADDR_W-1:0]          wr_addr;
    logic [CADDR_W-1:0]          rd_addr;
    logic                        coef_wr;

    // per-section delay lines
    logic signed [SAMPLE_BITS-1:0] r_x1 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] r_x2 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] r_y1 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] r_y2 [MAX_SECTIONS];

    // section walk
    logic [SEC_W-1:0]              r_sec;
    logic [SEC_W-1:0]              r_last;
    logic [CADDR_W-1:0]            r_base;
    logic [SLOT_W-1:0]             r_k;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_clip;

    // mac pipeline: coefficient read, multiply, accumulate
    logic                          r_s1_vld;
    logic [SLOT_W-1:0]             r_s1_k;
    logic                          r_s2_vld;
    logic                          r_s2_neg;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0] mul_b;

    // write-back of one section
    logic signed [ACC_W-1:0]       y_full;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_clip;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;

    // handshake and sequencer strobes
    logic in_xfer;
    logic start;
    logic issue;
    logic drain_done;
    logic out_load;

    // ---------------------------------------------------------------
    // apb register port: one register, the section count at byte address 0
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SECTION_COUNT);
    assign prdata = (paddr[2] == REG_SECTION_COUNT) ? {{(32 - CFG_W){1'b0}}, r_section_count}
                                                    : 32'd0;

    // zero acts as one section, anything above the maximum as the maximum
    always_comb begin
        if (r_section_count == '0) begin
            last_idx = '0;
        end else if (32'(r_section_count) > MAX_SECTIONS) begin
            last_idx = SEC_W'(MAX_SECTIONS - 1);
        end else begin
            last_idx = SEC_W'(r_section_count - CFG_W'(1));
        end
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    assign in_xfer = i_in_valid && !o_in_stall;
    assign start   = in_xfer && (i_func == FUNC_FILTER);

    // writes to a bad slot or section are dropped
    assign coef_wr = in_xfer && (i_func == FUNC_COEF)
                     && (32'(i_coef_slot) < SLOTS)
                     && (32'(i_coef_section) < MAX_SECTIONS);
    assign wr_addr = CADDR_W'(32'(i_coef_section) * SLOTS + 32'(i_coef_slot));
    assign rd_addr = r_base + CADDR_W'(r_k);

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                // all five coefficient reads issued
                if (r_k == SLOT_A2) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = (r_sec == r_last) ? ST_DONE : ST_MAC;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: strobes
    // ---------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        drain_done = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_MAC:   issue      = 1'b1;
            // accumulator is final once both pipeline stages are empty
            ST_DRAIN: drain_done = !r_s1_vld && !r_s2_vld;
            // result waits here until the output register is free
            ST_DONE:  out_load   = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // coefficient store, registered read
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            r_coef_mem[wr_addr] <= i_coef_value;
        end
        if (issue) begin
            r_coef_q <= r_coef_mem[rd_addr];
            r_cvld_q <= r_coef_vld[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier operands: never-written coefficients read as zero
    // ---------------------------------------------------------------
    assign mul_a = r_cvld_q ? r_coef_q : '0;

    always_comb begin
        unique case (r_s1_k)
            SLOT_B0: mul_b = r_x;
            SLOT_B1: mul_b = r_x1[r_sec];
            SLOT_B2: mul_b = r_x2[r_sec];
            SLOT_A1: mul_b = r_y1[r_sec];
            SLOT_A2: mul_b = r_y2[r_sec];
            default: mul_b = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // round half up (bias preloaded in the accumulator), then saturate
    // ---------------------------------------------------------------
    assign y_full = r_acc >>> COEF_FRAC;

    always_comb begin
        if (y_full > Y_MAX) begin
            y_sat  = Y_MAX[SAMPLE_BITS-1:0];
            y_clip = 1'b1;
        end else if (y_full < Y_MIN) begin
            y_sat  = Y_MIN[SAMPLE_BITS-1:0];
            y_clip = 1'b1;
        end else begin
            y_sat  = y_full[SAMPLE_BITS-1:0];
            y_clip = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= CFG_W'(1);
            r_coef_vld      <= '0;
            r_k             <= '0;
            r_sec           <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_section_count <= pwdata[CFG_W-1:0];
            end
            if (coef_wr) begin
                r_coef_vld[wr_addr] <= 1'b1;
            end

            // slot counter walks b0..a2 once per section
            if (issue) begin
                r_k <= (r_k == SLOT_A2) ? SLOT_B0 : r_k + SLOT_W'(1);
            end
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;

            if (start) begin
                r_sec <= '0;
            end else if (drain_done) begin
                r_sec <= r_sec + SEC_W'(1);
            end

            // section write-back: shift the delay lines
            if (drain_done) begin
                r_x2[r_sec] <= r_x1[r_sec];
                r_x1[r_sec] <= r_x;
                r_y2[r_sec] <= r_y1[r_sec];
                r_y1[r_sec] <= y_sat;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_x    <= i_sample_in;
            r_base <= '0;
            r_last <= last_idx;
            r_clip <= 1'b0;
        end else if (drain_done) begin
            // section output feeds the next section
            r_x    <= y_sat;
            r_base <= r_base + CADDR_W'(SLOTS);
            r_clip <= r_clip | y_clip;
        end

        if (issue) begin
            r_s1_k <= r_k;
        end

        if (r_s1_vld) begin
            r_prod   <= PROD_W'(mul_a) * PROD_W'(mul_b);
            r_s2_neg <= (r_s1_k == SLOT_A1) || (r_s1_k == SLOT_A2);
        end

        if (start || drain_done) begin
            r_acc <= ACC_ROUND;
        end else if (r_s2_vld) begin
            r_acc <= r_s2_neg ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end

        if (out_load) begin
            r_out_sample <= r_x;
            r_out_sat    <= r_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

endmodule

// File: rtl/core/cbq_checker.sv
// port-level checker for the biquad cascade, bound to the top level
`include "cascaded_biquad_iir_filter_macros.svh"

module cbq_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   i_func,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [cbq_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input logic                                   o_saturated,
    input logic                                   pready
);
    import cbq_pkg::*;

    // register port never inserts wait states
    `CBQ_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")

    // a sample transfer puts the block to work, so input stalls next cycle
    `CBQ_ASSERT(a_busy_after_sample, i_in_valid && !o_in_stall && i_func == FUNC_FILTER |=> o_in_stall, "input not stalled after sample transfer")

    // a result can only appear while a sample was in progress
    `CBQ_ASSERT(a_result_from_work, $rose(o_out_valid) |-> $past(o_in_stall), "result appeared while idle")

    // stalled result holds value and flag
    `CBQ_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out) && $stable(o_saturated), "stalled result changed")

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (.*);

// File: dv/cascaded_biquad_iir_filter_test.sv
// self-checking testbench for the cascaded biquad filter: directed and random traffic against a fixed-point model
module cascaded_biquad_iir_filter_test;
    import cbq_pkg::*;

    // one transfer on the input channel
    typedef struct {
        logic                          func;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic        [SECIDX_W-1:0]    section;
        logic        [SLOT_W-1:0]      slot;
        logic signed [COEF_BITS-1:0]   value;
    } t_filter_item;

    // one transfer on the output channel
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } t_filter_output;

    localparam logic [2:0] SECTION_COUNT_ADDR = 3'(4 * int'(REG_SECTION_COUNT));
    localparam longint     SAMPLE_TOP         = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint     SAMPLE_BOT         = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [COEF_BITS-1:0] COEF_ONE  = 32'sd1 <<< COEF_FRAC;
    localparam logic signed [COEF_BITS-1:0] COEF_HALF = 32'sd1 <<< (COEF_FRAC - 1);
    // worst-case block latency with every section in use, plus margin
    localparam int SETTLE_CYCLES = 8 * MAX_SECTIONS + 1 + 20;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic                          i_func         = FUNC_FILTER;
    logic signed [SAMPLE_BITS-1:0] i_sample_in    = '0;
    logic        [SECIDX_W-1:0]    i_coef_section = '0;
    logic        [SLOT_W-1:0]      i_coef_slot    = '0;
    logic signed [COEF_BITS-1:0]   i_coef_value   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_saturated;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [2:0]                    paddr          = '0;
    logic [31:0]                   pwdata         = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // items waiting to be sent and outputs the model has predicted
    t_filter_item   filter_items[$];
    t_filter_output expected_outputs[$];
    int             failures = 0;

    // model copy of the block state
    logic signed [SAMPLE_BITS-1:0] x_d1 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] x_d2 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] y_d1 [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] y_d2 [MAX_SECTIONS];
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_SECTIONS][SLOTS];
    int unsigned                   sections_cfg = 1;

    // handshake pacing state
    int unsigned send_gap   = 0;
    int unsigned send_calm  = 0;
    int unsigned stall_left = 0;
    int unsigned recv_calm  = 0;

    cascaded_biquad_iir_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_sample_in    (i_sample_in),
        .i_coef_section (i_coef_section),
        .i_coef_slot    (i_coef_slot),
        .i_coef_value   (i_coef_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .o_saturated    (o_saturated),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // zero is read as one section, anything past the array as all of them
    function automatic int active_sections(int unsigned cfg);
        if (cfg == 0) begin
            return 1;
        end
        return (cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(cfg);
    endfunction

    // advance the model by one accepted item, queueing an output for samples
    function automatic void apply_item(t_filter_item it);
        longint                        acc;
        longint                        y;
        logic signed [SAMPLE_BITS-1:0] v;
        logic                          clip;
        int                            n;
        if (it.func == FUNC_COEF) begin
            // slots past a2 are dropped; every 4-bit section index is in range
            if (it.slot < SLOTS) begin
                coef_mem[it.section][it.slot] = it.value;
            end
            return;
        end
        n    = active_sections(sections_cfg);
        v    = it.sample;
        clip = 1'b0;
        for (int s = 0; s < n; s++) begin
            // exact sum of products, then round half up and shift back to sample scale
            acc = longint'(coef_mem[s][SLOT_B0]) * longint'(v)
                + longint'(coef_mem[s][SLOT_B1]) * longint'(x_d1[s])
                + longint'(coef_mem[s][SLOT_B2]) * longint'(x_d2[s])
                - longint'(coef_mem[s][SLOT_A1]) * longint'(y_d1[s])
                - longint'(coef_mem[s][SLOT_A2]) * longint'(y_d2[s])
                + (64'sd1 <<< (COEF_FRAC - 1));
            y = acc >>> COEF_FRAC;
            if (y > SAMPLE_TOP) begin
                y    = SAMPLE_TOP;
                clip = 1'b1;
            end else if (y < SAMPLE_BOT) begin
                y    = SAMPLE_BOT;
                clip = 1'b1;
            end
            x_d2[s] = x_d1[s];
            x_d1[s] = v;
            y_d2[s] = y_d1[s];
            y_d1[s] = SAMPLE_BITS'(y);
            v       = SAMPLE_BITS'(y);
        end
        expected_outputs.push_back('{sample_out: v, saturated: clip});
    endfunction

    // coefficient write; the unused sample field still carries noise
    function automatic t_filter_item coef_item(int unsigned section, int unsigned slot,
                                               logic signed [COEF_BITS-1:0] value);
        t_filter_item it;
        it.func    = FUNC_COEF;
        it.sample  = SAMPLE_BITS'($urandom);
        it.section = SECIDX_W'(section);
        it.slot    = SLOT_W'(slot);
        it.value   = value;
        return it;
    endfunction

    // filter sample; the unused coefficient fields still carry noise
    function automatic t_filter_item sample_item(logic signed [SAMPLE_BITS-1:0] value);
        t_filter_item it;
        it.func    = FUNC_FILTER;
        it.sample  = value;
        it.section = SECIDX_W'($urandom);
        it.slot    = SLOT_W'($urandom);
        it.value   = COEF_BITS'($urandom);
        return it;
    endfunction

    // moderate coefficients so long cascades do not clip on every sample
    function automatic logic signed [COEF_BITS-1:0] sane_coef(int unsigned slot);
        int unsigned span;
        span = (slot == SLOT_B0 || slot == SLOT_A1) ? (32'd1 << 29) : (32'd1 << 28);
        return COEF_BITS'(int'($urandom_range(2 * span, 0)) - int'(span));
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        if ($urandom_range(99, 0) < 60) begin
            return SAMPLE_BITS'($urandom);
        end
        return SAMPLE_BITS'(int'($urandom_range(32'd1 << 21, 0)) - (32'sd1 <<< 20));
    endfunction

    // sender: holds the payload while stalled, then inserts a random gap
    always @(posedge i_clk) begin : feeder
        t_filter_item it;
        int unsigned  roll;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
            send_calm  <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (filter_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                it             = filter_items.pop_front();
                i_func         <= it.func;
                i_sample_in    <= it.sample;
                i_coef_section <= it.section;
                i_coef_slot    <= it.slot;
                i_coef_value   <= it.value;
                i_in_valid     <= 1'b1;
                roll = $urandom_range(99, 0);
                // mostly short gaps, a few long ones, and now and then a run with none
                if (send_calm != 0) begin
                    send_gap  <= 0;
                    send_calm <= send_calm - 1;
                end else if (roll < 5) begin
                    send_gap  <= 0;
                    send_calm <= $urandom_range(60, 20);
                end else if (roll < 50) begin
                    send_gap <= 0;
                end else if (roll < 92) begin
                    send_gap <= $urandom_range(3, 1);
                end else begin
                    send_gap <= $urandom_range(40, 10);
                end
            end
        end
    end

    // receiver back-pressure, independent of the output valid
    always @(posedge i_clk) begin : sink
        int unsigned roll;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            recv_calm   <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (recv_calm != 0) begin
            i_out_stall <= 1'b0;
            recv_calm   <= recv_calm - 1;
        end else begin
            roll = $urandom_range(99, 0);
            if (roll < 4) begin
                i_out_stall <= 1'b0;
                recv_calm   <= $urandom_range(80, 20);
            end else if (roll < 65) begin
                i_out_stall <= 1'b0;
            end else if (roll < 95) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(2, 0);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(40, 10);
            end
        end
    end

    // monitor: model every accepted input, check every accepted output
    always @(posedge i_clk) begin : monitor
        t_filter_item   seen;
        t_filter_output want;
        if (!i_rst_n) begin
            // model state after reset: zero delays and coefficients
            foreach (x_d1[s]) begin
                x_d1[s] = '0;
                x_d2[s] = '0;
                y_d1[s] = '0;
                y_d2[s] = '0;
            end
            foreach (coef_mem[s, k]) begin
                coef_mem[s][k] = '0;
            end
            sections_cfg = 1;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                seen.func    = i_func;
                seen.sample  = i_sample_in;
                seen.section = i_coef_section;
                seen.slot    = i_coef_slot;
                seen.value   = i_coef_value;
                apply_item(seen);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    $error("unexpected output transfer: sample_out %0d, saturated %0b",
                           o_sample_out, o_saturated);
                    failures++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_sample_out !== want.sample_out) begin
                        $error("sample_out: expected %0d, actual %0d",
                               want.sample_out, o_sample_out);
                        failures++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, o_saturated);
                        failures++;
                    end
                end
            end
        end
    end

    // setup cycle then access cycle; the write lands on the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // idle means nothing queued, nothing on the wire and nothing outstanding
    task automatic wait_drained();
        while (filter_items.size() != 0 || i_in_valid || expected_outputs.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_counts [6];
        int unsigned roll;
        int          n_eff;
        logic [31:0] readback;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one section in use, coefficients still at reset
        filter_items.push_back(sample_item(24'sh7FFFFF));
        // unity gain pass-through at both sample extremes
        filter_items.push_back(coef_item(0, SLOT_B0, COEF_ONE));
        filter_items.push_back(sample_item(24'sh7FFFFF));
        filter_items.push_back(sample_item(24'sh800000));
        filter_items.push_back(sample_item(24'sh000000));
        filter_items.push_back(sample_item(-24'sd1));
        // half gain: odd samples land exactly on the rounding midpoint
        filter_items.push_back(coef_item(0, SLOT_B0, COEF_HALF));
        filter_items.push_back(sample_item(24'sd1));
        filter_items.push_back(sample_item(-24'sd1));
        filter_items.push_back(sample_item(24'sd3));
        // extreme coefficients drive the output into both rails
        filter_items.push_back(coef_item(0, SLOT_B0, 32'sh7FFFFFFF));
        filter_items.push_back(sample_item(24'sh7FFFFF));
        filter_items.push_back(coef_item(0, SLOT_B0, 32'sh80000000));
        filter_items.push_back(sample_item(24'sh800000));
        filter_items.push_back(sample_item(24'sh7FFFFF));
        // full section with feed-forward and feedback taps
        filter_items.push_back(coef_item(0, SLOT_B0, COEF_HALF));
        filter_items.push_back(coef_item(0, SLOT_B1, COEF_ONE));
        filter_items.push_back(coef_item(0, SLOT_B2, -COEF_ONE));
        filter_items.push_back(coef_item(0, SLOT_A1, -COEF_HALF));
        filter_items.push_back(coef_item(0, SLOT_A2, COEF_HALF >>> 1));
        // writes to slots past a2 must be ignored
        filter_items.push_back(coef_item(0, SLOTS, 32'sh7FFFFFFF));
        filter_items.push_back(coef_item(0, (1 << SLOT_W) - 1, 32'sh80000000));
        // a section outside the cascade takes the write but stays idle
        filter_items.push_back(coef_item(MAX_SECTIONS - 1, SLOT_B0, COEF_ONE));
        filter_items.push_back(sample_item(24'sd1000));
        filter_items.push_back(sample_item(-24'sd5000));
        filter_items.push_back(sample_item(24'sh7FFFFF));
        filter_items.push_back(sample_item(24'sd12345));

        // random phases; zero and oversize counts included, the last one random
        phase_counts = '{1, MAX_SECTIONS, 0, 31, MAX_SECTIONS + 1, 0};
        phase_counts[5] = $urandom_range(MAX_SECTIONS - 1, 2);
        foreach (phase_counts[p]) begin
            // register writes only with the block idle and its pipeline drained
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            apb_write(SECTION_COUNT_ADDR, phase_counts[p]);
            sections_cfg = phase_counts[p] & 32'h1F;
            apb_read(SECTION_COUNT_ADDR, readback);
            if (readback !== {27'd0, 5'(phase_counts[p])}) begin
                $error("section count readback: expected %0d, actual %0d",
                       phase_counts[p] & 32'h1F, readback);
                failures++;
            end
            @(negedge i_clk);
            n_eff = active_sections(sections_cfg);

            // first two phases load every section in use, later ones touch a few taps
            if (p < 2) begin
                for (int s = 0; s < n_eff; s++) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        filter_items.push_back(coef_item(s, k, sane_coef(k)));
                    end
                end
            end else begin
                repeat (6) begin
                    roll = $urandom_range(SLOTS - 1, 0);
                    filter_items.push_back(coef_item($urandom_range(n_eff - 1, 0),
                                                     roll, sane_coef(roll)));
                end
            end

            for (int i = 0; i < 45; i++) begin
                // one mid-phase pause with every output collected
                if (p == 2 && i == 20) begin
                    wait_drained();
                    repeat ($urandom_range(20, 5)) @(negedge i_clk);
                end
                roll = $urandom_range(99, 0);
                if (roll >= 10) begin
                    filter_items.push_back(sample_item(random_sample()));
                end else begin
                    // stray coefficient writes: bad slots, wild values, mild values
                    roll = $urandom_range(99, 0);
                    if (roll < 40) begin
                        filter_items.push_back(coef_item($urandom_range(MAX_SECTIONS - 1, 0),
                                                         $urandom_range((1 << SLOT_W) - 1, SLOTS),
                                                         COEF_BITS'($urandom)));
                    end else if (roll < 55) begin
                        filter_items.push_back(coef_item($urandom_range(MAX_SECTIONS - 1, 0),
                                                         $urandom_range(SLOTS - 1, 0),
                                                         COEF_BITS'($urandom)));
                    end else begin
                        roll = $urandom_range(SLOTS - 1, 0);
                        filter_items.push_back(coef_item($urandom_range(MAX_SECTIONS - 1, 0),
                                                         roll, sane_coef(roll)));
                    end
                end
            end
        end

        // drain, then give any stray output time to show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (failures == 0 && expected_outputs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
